FILE: src/sfa_pkg.sv
package sfa_pkg;

  // Default sizes of the two stacks and of a stored frame number.
  localparam int unsigned DEF_LOW_DEPTH  = 4096;
  localparam int unsigned DEF_HIGH_DEPTH = 4096;
  localparam int unsigned DEF_FRAME_BITS = 40;

  // Field widths on the ports.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned STAT_W  = 2;

  // Frames whose address lies below the 4 GiB boundary belong to the low stack.
  localparam logic [31:0] BOUNDARY_ADDR  = 32'hFFFF_F000;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam logic [FRAME_W-1:0] LOW_TOP_FRAME =
    FRAME_W'(BOUNDARY_ADDR >> PAGE_SHIFT);
  localparam int unsigned LOW_FRAME_BITS = 32 - PAGE_SHIFT;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_POP_LOW   = 3'd2,
    OP_POP_RESV  = 3'd3,
    OP_RESERVE   = 3'd4,
    OP_UNRESERVE = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD     = 2'd3
  } status_e;

  // Which stack, if any, supplies the frame of a result.
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_LOW  = 2'd1,
    SRC_HIGH = 2'd2
  } src_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FRAME_W-1:0] frame_number;
    logic [COUNT_W-1:0] frame_count;
  } req_t;

  typedef struct packed {
    status_e            status;
    src_e               src;
    logic [COUNT_W-1:0] frames_free;
    logic [COUNT_W-1:0] frames_held;
  } result_t;

endpackage

FILE: src/sfa_stack_mem.sv
module sfa_stack_mem
  import sfa_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_LOW_DEPTH,
  parameter int unsigned WIDTH = LOW_FRAME_BITS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data is held until the next read, so a stalled result keeps its frame.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/sfa_ctrl.sv
module sfa_ctrl
  import sfa_pkg::*;
#(
  parameter int unsigned LOW_DEPTH  = DEF_LOW_DEPTH,
  parameter int unsigned HIGH_DEPTH = DEF_HIGH_DEPTH,
  parameter int unsigned FRAME_BITS = DEF_FRAME_BITS,
  localparam int unsigned LAW = $clog2(LOW_DEPTH),
  localparam int unsigned HAW = $clog2(HIGH_DEPTH),
  localparam int unsigned HW  = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  req_t                  req_i,
  output logic                  low_wr_en_o,
  output logic [LAW-1:0]        low_wr_addr_o,
  output logic [LOW_FRAME_BITS-1:0] low_wr_data_o,
  output logic                  low_rd_en_o,
  output logic [LAW-1:0]        low_rd_addr_o,
  output logic                  high_wr_en_o,
  output logic [HAW-1:0]        high_wr_addr_o,
  output logic [HW-1:0]         high_wr_data_o,
  output logic                  high_rd_en_o,
  output logic [HAW-1:0]        high_rd_addr_o,
  output result_t               result_o
);

  localparam int unsigned LFW   = $clog2(LOW_DEPTH + 1);
  localparam int unsigned HFW   = $clog2(HIGH_DEPTH + 1);
  localparam int unsigned TOT_W = $clog2(LOW_DEPTH + HIGH_DEPTH + 1);
  localparam int unsigned CW    = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;

  logic [LFW-1:0] low_fill_q, low_fill_d, low_fill_dec;
  logic [HFW-1:0] high_fill_q, high_fill_d, high_fill_dec;
  logic [CW-1:0]  resv_q, resv_d;
  logic [CW-1:0]  free_now, free_next, count_ext;
  logic           low_we, high_we, low_pop, high_pop;
  logic           frame_bad, frame_is_low, prefer_high;
  status_e        status;
  result_t        result_q;

  assign free_now     = CW'(low_fill_q) + CW'(high_fill_q);
  assign count_ext    = CW'(req_i.frame_count);
  assign frame_bad    = (req_i.frame_number == '0) || ((req_i.frame_number >> FRAME_BITS) != '0);
  assign frame_is_low = (req_i.frame_number <= LOW_TOP_FRAME);
  assign prefer_high  = (high_fill_q != '0);
  assign low_fill_dec  = low_fill_q - 1'b1;
  assign high_fill_dec = high_fill_q - 1'b1;

  always_comb begin
    status   = ST_OK;
    low_we   = 1'b0;
    high_we  = 1'b0;
    low_pop  = 1'b0;
    high_pop = 1'b0;
    resv_d   = resv_q;
    unique case (op_e'(req_i.operation))
      OP_PUSH: begin
        if (frame_bad) begin
          status = ST_BAD;
        end else if (frame_is_low) begin
          if (low_fill_q == LFW'(LOW_DEPTH)) status = ST_FULL;
          else low_we = 1'b1;
        end else begin
          if (high_fill_q == HFW'(HIGH_DEPTH)) status = ST_FULL;
          else high_we = 1'b1;
        end
      end
      OP_POP: begin
        if (free_now <= resv_q) begin
          status = ST_REFUSED;
        end else begin
          high_pop = prefer_high;
          low_pop  = !prefer_high;
        end
      end
      OP_POP_LOW: begin
        if (low_fill_q == '0) status = ST_REFUSED;
        else low_pop = 1'b1;
      end
      OP_POP_RESV: begin
        if (resv_q == '0 || free_now == '0) begin
          status = ST_BAD;
        end else begin
          resv_d   = resv_q - 1'b1;
          high_pop = prefer_high;
          low_pop  = !prefer_high;
        end
      end
      OP_RESERVE: begin
        if (free_now < resv_q || (free_now - resv_q) < count_ext) status = ST_REFUSED;
        else resv_d = resv_q + count_ext;
      end
      OP_UNRESERVE: begin
        if (count_ext > resv_q) status = ST_BAD;
        else resv_d = resv_q - count_ext;
      end
      default: status = ST_BAD;
    endcase
  end

  always_comb begin
    low_fill_d  = low_fill_q;
    high_fill_d = high_fill_q;
    if (low_we)   low_fill_d  = low_fill_q + 1'b1;
    if (low_pop)  low_fill_d  = low_fill_dec;
    if (high_we)  high_fill_d = high_fill_q + 1'b1;
    if (high_pop) high_fill_d = high_fill_dec;
  end

  assign free_next = CW'(low_fill_d) + CW'(high_fill_d);

  assign low_wr_en_o    = advance_i && low_we;
  assign low_wr_addr_o  = low_fill_q[LAW-1:0];
  assign low_wr_data_o  = req_i.frame_number[LOW_FRAME_BITS-1:0];
  assign low_rd_en_o    = advance_i && low_pop;
  assign low_rd_addr_o  = low_fill_dec[LAW-1:0];
  assign high_wr_en_o   = advance_i && high_we;
  assign high_wr_addr_o = high_fill_q[HAW-1:0];
  assign high_wr_data_o = req_i.frame_number[HW-1:0];
  assign high_rd_en_o   = advance_i && high_pop;
  assign high_rd_addr_o = high_fill_dec[HAW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_fill_q  <= '0;
      high_fill_q <= '0;
      resv_q      <= '0;
    end else if (advance_i) begin
      low_fill_q  <= low_fill_d;
      high_fill_q <= high_fill_d;
      resv_q      <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      result_q.status      <= status;
      result_q.src         <= high_pop ? SRC_HIGH : (low_pop ? SRC_LOW : SRC_NONE);
      result_q.frames_free <= free_next[COUNT_W-1:0];
      result_q.frames_held <= resv_d[COUNT_W-1:0];
    end
  end

  assign result_o = result_q;

endmodule

FILE: src/split_free_frame_stack_allocator_unit.sv
// Channel   Direction  Width  Contents
// s_axis    in         3+56   tuser: operation; tdata: frame_number, frame_count
// m_axis    out        2+72   tuser: status; tdata: frame_out, frames_free, frames_held
//
// One request is taken in every cycle while the result side does not stall;
// its result is held in the request register and then the result register
// before it is offered. The stack memories have a registered read port: the
// decision is made from the request register, and the frame read from the
// top of a stack arrives in the same edge as the rest of the result.
// Reset clears the fill counts and the reservation count; stack contents are
// not cleared, since only entries below a fill count are ever read.
// A stalled result holds both stages; while it waits, one more request can
// still be taken into an empty request register.
module split_free_frame_stack_allocator_unit
  import sfa_pkg::*;
#(
  parameter int unsigned LOW_DEPTH  = DEF_LOW_DEPTH,
  parameter int unsigned HIGH_DEPTH = DEF_HIGH_DEPTH,
  parameter int unsigned FRAME_BITS = DEF_FRAME_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [39:0] frame_number, [53:40] frame_count
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [39:0] frame_out, [53:40] frames_free,
                                      // [67:54] frames_held
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned LAW = $clog2(LOW_DEPTH);
  localparam int unsigned HAW = $clog2(HIGH_DEPTH);
  localparam int unsigned HW  = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;

  // Request register with its valid flag, and the result valid flag.
  req_t req_q;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance, s_accept;

  logic                      low_wr_en, low_rd_en, high_wr_en, high_rd_en;
  logic [LAW-1:0]            low_wr_addr, low_rd_addr;
  logic [HAW-1:0]            high_wr_addr, high_rd_addr;
  logic [LOW_FRAME_BITS-1:0] low_wr_data, low_rd_data;
  logic [HW-1:0]             high_wr_data, high_rd_data;
  result_t                   result;
  logic [FRAME_W-1:0]        frame_out;

  // The request stage moves on whenever it holds a request and the result register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q.operation    <= s_axis_tuser;
      req_q.frame_number <= s_axis_tdata[39:0];
      req_q.frame_count  <= s_axis_tdata[53:40];
    end
  end

  sfa_ctrl #(
    .LOW_DEPTH  (LOW_DEPTH),
    .HIGH_DEPTH (HIGH_DEPTH),
    .FRAME_BITS (FRAME_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .req_i          (req_q),
    .low_wr_en_o    (low_wr_en),
    .low_wr_addr_o  (low_wr_addr),
    .low_wr_data_o  (low_wr_data),
    .low_rd_en_o    (low_rd_en),
    .low_rd_addr_o  (low_rd_addr),
    .high_wr_en_o   (high_wr_en),
    .high_wr_addr_o (high_wr_addr),
    .high_wr_data_o (high_wr_data),
    .high_rd_en_o   (high_rd_en),
    .high_rd_addr_o (high_rd_addr),
    .result_o       (result)
  );

  // Low stack: frames at or below the boundary, stored without their zero upper bits.
  sfa_stack_mem #(
    .DEPTH (LOW_DEPTH),
    .WIDTH (LOW_FRAME_BITS)
  ) u_low_stack (
    .clk_i     (clk_i),
    .wr_en_i   (low_wr_en),
    .wr_addr_i (low_wr_addr),
    .wr_data_i (low_wr_data),
    .rd_en_i   (low_rd_en),
    .rd_addr_i (low_rd_addr),
    .rd_data_o (low_rd_data)
  );

  // High stack: every other frame.
  sfa_stack_mem #(
    .DEPTH (HIGH_DEPTH),
    .WIDTH (HW)
  ) u_high_stack (
    .clk_i     (clk_i),
    .wr_en_i   (high_wr_en),
    .wr_addr_i (high_wr_addr),
    .wr_data_i (high_wr_data),
    .rd_en_i   (high_rd_en),
    .rd_addr_i (high_rd_addr),
    .rd_data_o (high_rd_data)
  );

  // Only a successful pop shows a frame; every other result carries frame zero.
  always_comb begin
    unique case (result.src)
      SRC_LOW:  frame_out = FRAME_W'(low_rd_data);
      SRC_HIGH: frame_out = FRAME_W'(high_rd_data);
      default:  frame_out = '0;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result.status;
  assign m_axis_tdata  = {4'b0, result.frames_held, result.frames_free, frame_out};

  // A result that is not a plain success never carries a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[39:0] == '0)
    else $error("frame given with a failing status");

  // A pending request always reaches the result register once the output can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && m_axis_tready |=> out_valid_q)
    else $error("request lost between stages");

endmodule

FILE: sim/split_free_frame_stack_allocator_unit_test.sv
`timescale 1ns / 1ps

// Checks the split free-frame stack allocator over its streaming ports.
// Each request is predicted when it is accepted: the expected outcome is
// computed from a local copy of both stacks and of the reservation count and
// queued. A checking process compares every result against the oldest queued
// outcome. Three test tasks run in turn: directed corner cases, a long
// random mix of operations, and a pass that reserves every free frame.
module split_free_frame_stack_allocator_unit_test;
  import sfa_pkg::*;

  // Operation codes that the block does not define; both must be answered as bad.
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic [FRAME_W-1:0] HIGH_FIRST_FRAME = LOW_TOP_FRAME + 1'b1;
  localparam logic [FRAME_W-1:0] FRAME_ONES       = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONES       = '1;

  // One expected or observed result, field for field.
  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] free;
    logic [COUNT_W-1:0] held;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  split_free_frame_stack_allocator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the allocator: both stacks, their fill levels and the
  // number of frames set aside by reservations.
  logic [LOW_FRAME_BITS-1:0] low_frames  [DEF_LOW_DEPTH];
  logic [FRAME_W-1:0]        high_frames [DEF_HIGH_DEPTH];
  int unsigned               low_top;
  int unsigned               high_top;
  int unsigned               held_total;

  outcome_t    pending_outcomes[$];
  int unsigned mismatches;

  // When set, the sender or the receiver runs without idle cycles.
  bit tx_quiet;
  bit rx_quiet;

  function automatic logic [FRAME_W-1:0] take_low();
    low_top--;
    return FRAME_W'(low_frames[low_top]);
  endfunction

  // The high stack is preferred; the caller makes sure one stack has a frame.
  function automatic logic [FRAME_W-1:0] take_preferred();
    if (high_top > 0) begin
      high_top--;
      return high_frames[high_top];
    end
    return take_low();
  endfunction

  // Applies one request to the local copy and returns what the block must answer.
  function automatic outcome_t predict_outcome(logic [OP_W-1:0] op,
                                               logic [FRAME_W-1:0] frame,
                                               logic [COUNT_W-1:0] count);
    outcome_t    res;
    int unsigned free_now;
    res.status = ST_OK;
    res.frame  = '0;
    free_now   = low_top + high_top;
    case (op)
      OP_PUSH: begin
        if (frame == '0 || (64'(frame) >> DEF_FRAME_BITS) != 64'd0) begin
          res.status = ST_BAD;
        end else if (frame <= LOW_TOP_FRAME) begin
          if (low_top >= DEF_LOW_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            low_frames[low_top] = frame[LOW_FRAME_BITS-1:0];
            low_top++;
          end
        end else begin
          if (high_top >= DEF_HIGH_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            high_frames[high_top] = frame;
            high_top++;
          end
        end
      end
      OP_POP: begin
        if (free_now <= held_total) res.status = ST_REFUSED;
        else res.frame = take_preferred();
      end
      OP_POP_LOW: begin
        if (low_top == 0) res.status = ST_REFUSED;
        else res.frame = take_low();
      end
      OP_POP_RESV: begin
        if (held_total == 0 || free_now == 0) begin
          res.status = ST_BAD;
        end else begin
          held_total--;
          res.frame = take_preferred();
        end
      end
      OP_RESERVE: begin
        if (free_now < held_total || free_now - held_total < count) res.status = ST_REFUSED;
        else held_total += count;
      end
      OP_UNRESERVE: begin
        if (count > held_total) res.status = ST_BAD;
        else held_total -= count;
      end
      default: res.status = ST_BAD;
    endcase
    res.free = COUNT_W'(low_top + high_top);
    res.held = COUNT_W'(held_total);
    return res;
  endfunction

  function automatic int unsigned tx_gap();
    return tx_quiet ? 0 : $urandom_range(19, 0);
  endfunction

  function automatic int unsigned rx_gap();
    return rx_quiet ? 0 : $urandom_range(19, 0);
  endfunction

  function automatic logic [FRAME_W-1:0] rand_any_frame();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [FRAME_W-1:0] rand_low_frame();
    return FRAME_W'($urandom_range(32'(LOW_TOP_FRAME), 1));
  endfunction

  function automatic logic [FRAME_W-1:0] rand_high_frame();
    logic [FRAME_W-1:0] f;
    f = rand_any_frame();
    if (f <= LOW_TOP_FRAME) f[FRAME_W-1] = 1'b1;
    return f;
  endfunction

  // Mostly small counts so that reservations succeed, now and then any value.
  function automatic logic [COUNT_W-1:0] rand_count();
    if ($urandom_range(9, 0) == 0) return COUNT_W'($urandom);
    return COUNT_W'($urandom_range(4, 0));
  endfunction

  // Presents one request after a random idle gap and holds it until it is
  // accepted; the expected outcome is queued at the accepting edge. A gap of
  // zero keeps tvalid high so that requests follow back to back.
  task automatic send_req(logic [OP_W-1:0] op, logic [FRAME_W-1:0] frame,
                          logic [COUNT_W-1:0] count);
    int unsigned gap;
    gap = tx_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, count, frame};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.push_back(predict_outcome(op, frame, count));
  endtask

  // Result side: a random stall before each result, then the result is
  // compared against the oldest expected outcome.
  initial begin
    int unsigned stall;
    outcome_t    seen;
    outcome_t    want;
    m_axis_tready = 1'b0;
    forever begin
      stall = rx_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && rst_ni));
      seen.status = status_e'(m_axis_tuser);
      seen.frame  = m_axis_tdata[39:0];
      seen.free   = m_axis_tdata[53:40];
      seen.held   = m_axis_tdata[67:54];
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: status %0d frame %h free %0d held %0d",
                 $realtime, seen.status, seen.frame, seen.free, seen.held);
      end else begin
        want = pending_outcomes.pop_front();
        if (seen !== want) begin
          mismatches++;
          $display("%0t: expected status %0d frame %h free %0d held %0d,",
                   $realtime, want.status, want.frame, want.free, want.held);
          $display("%0t: got status %0d frame %h free %0d held %0d",
                   $realtime, seen.status, seen.frame, seen.free, seen.held);
        end
      end
    end
  end

  // Corner cases on an empty allocator: refusals, the boundary frames,
  // undefined codes, and the reservation rules at their edges.
  task automatic test_directed_cases();
    send_req(OP_POP, rand_any_frame(), rand_count());           // nothing free
    send_req(OP_POP_LOW, rand_any_frame(), rand_count());       // low stack empty
    send_req(OP_POP_RESV, rand_any_frame(), rand_count());      // nothing reserved
    send_req(OP_PUSH, '0, COUNT_ONES);                          // frame zero is bad
    send_req(OP_PUSH, 40'd1, '0);                               // lowest frame
    send_req(OP_PUSH, LOW_TOP_FRAME, rand_count());             // last frame below 4 GiB
    send_req(OP_PUSH, HIGH_FIRST_FRAME, rand_count());          // first frame above it
    send_req(OP_PUSH, FRAME_ONES, rand_count());                // widest frame
    send_req(OP_UNDEF_LO, rand_any_frame(), COUNT_ONES);
    send_req(OP_UNDEF_HI, FRAME_ONES, rand_count());
    send_req(OP_RESERVE, rand_any_frame(), '0);
    send_req(OP_RESERVE, '0, 14'd5);                            // more than is free
    send_req(OP_RESERVE, '0, 14'd3);
    send_req(OP_POP, '0, '0);                                   // takes the high stack
    send_req(OP_POP, '0, '0);                                   // all the rest reserved
    send_req(OP_POP_LOW, '0, '0);                               // ignores reservations
    send_req(OP_RESERVE, '0, 14'd1);                            // free below reserved
    send_req(OP_POP_RESV, '0, '0);
    send_req(OP_UNRESERVE, '0, 14'd3);                          // more than is reserved
    send_req(OP_UNRESERVE, FRAME_ONES, 14'd2);
    send_req(OP_POP_RESV, '0, '0);                              // nothing reserved now
    send_req(OP_RESERVE, '0, COUNT_ONES);
    send_req(OP_UNRESERVE, '0, COUNT_ONES);
    send_req(OP_POP, '0, '0);                                   // empties the stacks
    // A reservation left standing after a low-only pop takes the last frame.
    send_req(OP_PUSH, 40'd2, '0);
    send_req(OP_RESERVE, '0, 14'd1);
    send_req(OP_POP_LOW, '0, '0);
    send_req(OP_POP_RESV, '0, '0);                              // both stacks empty
    send_req(OP_UNRESERVE, '0, 14'd1);
  endtask

  // Random operations, weighted towards pushes so that the stacks hold frames
  // and the pops and reservations have something to work on. The idle
  // pattern of the two sides changes every few dozen requests.
  task automatic test_random_mix(int unsigned n_reqs);
    int unsigned        pick;
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] frame;
    for (int unsigned i = 0; i < n_reqs; i++) begin
      if (i % 60 == 0) begin
        tx_quiet = ($urandom_range(3, 0) == 0);
        rx_quiet = ($urandom_range(3, 0) == 0);
      end
      pick  = $urandom_range(99, 0);
      frame = rand_any_frame();
      if (pick < 40) begin
        op = OP_PUSH;
        case ($urandom_range(19, 0))
          0:       frame = '0;
          1:       frame = LOW_TOP_FRAME;
          2:       frame = HIGH_FIRST_FRAME;
          3:       frame = FRAME_ONES;
          default: frame = $urandom_range(1, 0) ? rand_low_frame() : rand_high_frame();
        endcase
      end else if (pick < 60) begin
        op = OP_POP;
      end else if (pick < 70) begin
        op = OP_POP_LOW;
      end else if (pick < 80) begin
        op = OP_POP_RESV;
      end else if (pick < 88) begin
        op = OP_RESERVE;
      end else if (pick < 96) begin
        op = OP_UNRESERVE;
      end else begin
        op = $urandom_range(1, 0) ? OP_UNDEF_LO : OP_UNDEF_HI;
      end
      send_req(op, frame, rand_count());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Pushes two frames, releases every reservation, then reserves every free frame at once,
  // takes one reserved frame and releases the rest before taking a few frames back.
  task automatic test_reserve_all();
    send_req(OP_PUSH, LOW_TOP_FRAME, '0);
    send_req(OP_PUSH, HIGH_FIRST_FRAME, '0);
    send_req(OP_UNRESERVE, '0, COUNT_W'(held_total));
    send_req(OP_RESERVE, '0, COUNT_W'(low_top + high_top));
    send_req(OP_POP, '0, '0);                                   // all reserved
    send_req(OP_POP_RESV, '0, '0);
    send_req(OP_UNRESERVE, '0, COUNT_W'(held_total));
    repeat (3) send_req(OP_POP_LOW, '0, '0);
    repeat (3) send_req(OP_POP, '0, '0);
    send_req(OP_POP_RESV, '0, '0);                              // nothing reserved
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    low_top       = 0;
    high_top      = 0;
    held_total    = 0;
    mismatches    = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_mix(1500);
    test_reserve_all();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    // Allow the two-stage pipeline to show any stray result.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Roughly 1.6k requests with their random idle gaps stay well inside this bound.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
src/sfa_pkg.sv
src/sfa_stack_mem.sv
src/sfa_ctrl.sv
src/split_free_frame_stack_allocator_unit.sv
sim/split_free_frame_stack_allocator_unit_test.sv
